[rtl/assert_macros.svh]
// assertion helpers shared by the blend pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define CHK_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("blend check failed");

// condition must never be seen outside reset
`define CHK_NEVER(lbl, clk_i, rstn_i, cond) \
	`CHK_ASSERT(lbl, clk_i, rstn_i, !(cond))

`endif

[rtl/taob_pkg.sv]
`default_nettype none

package taob_pkg;

	// channel scale: 255 means one
	localparam logic [7:0]  FULL_SCALE = 8'd255;
	// product of two channel scales
	localparam logic [15:0] SQ_SCALE   = 16'd65025;

	// lane numbering inside the divider
	localparam int unsigned NUM_COLOR = 3;
	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned ALPHA_LANE = 3;

	// configuration register index
	typedef enum logic [1:0] {
		REG_TINT_RED   = 2'd0,
		REG_TINT_GREEN = 2'd1,
		REG_TINT_BLUE  = 2'd2,
		REG_TINT_ALPHA = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} tint_t;

	// one source/destination request
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [31:0] dest;
	} pix_in_t;

	// numerators and alpha numerator handed to the divider
	typedef struct packed {
		logic                        valid;
		logic [23:0]                 na;
		logic [NUM_COLOR-1:0][31:0]  num;
	} blend_sum_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [1:0]  q;
	} div_pair_t;

	// two restoring division steps, quotient bits k and k-1
	function automatic div_pair_t div_pair(input logic [31:0] rem, input logic [23:0] den,
		input int unsigned k);
		logic [31:0] r;
		logic [31:0] t;
		div_pair_t   res;
		r = rem;
		t = {8'b0, den} << k;
		res.q[1] = (r >= t);
		if (res.q[1]) begin
			r = r - t;
		end
		t = {8'b0, den} << (k - 1);
		res.q[0] = (r >= t);
		if (res.q[0]) begin
			r = r - t;
		end
		res.rem = r;
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/taob_regs.sv]
`default_nettype none

module taob_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output taob_pkg::tint_t    tint
);
	import taob_pkg::*;

	tint_t    tint_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign tint   = tint_q;

	// tint registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_q <= '{red: FULL_SCALE, green: FULL_SCALE, blue: FULL_SCALE,
				alpha: FULL_SCALE};
		end else if (wr_en) begin
			unique case (idx)
				REG_TINT_RED:   tint_q.red   <= pwdata[7:0];
				REG_TINT_GREEN: tint_q.green <= pwdata[7:0];
				REG_TINT_BLUE:  tint_q.blue  <= pwdata[7:0];
				REG_TINT_ALPHA: tint_q.alpha <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_TINT_RED:   prdata = {24'b0, tint_q.red};
			REG_TINT_GREEN: prdata = {24'b0, tint_q.green};
			REG_TINT_BLUE:  prdata = {24'b0, tint_q.blue};
			REG_TINT_ALPHA: prdata = {24'b0, tint_q.alpha};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/taob_front.sv]
`default_nettype none

`include "assert_macros.svh"

module taob_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire taob_pkg::pix_in_t pix,
	input  wire taob_pkg::tint_t   tint,
	output taob_pkg::blend_sum_t   sum
);
	import taob_pkg::*;

	// stage 1: tinted source
	logic                       v_s1;
	logic [15:0]                a_s1;
	logic [NUM_COLOR-1:0][15:0] cs_s1;
	logic [7:0]                 da_s1;
	logic [NUM_COLOR-1:0][7:0]  d_s1;

	// stage 2: alpha numerator and partial products
	logic                       v_s2;
	logic [15:0]                sa_s2;
	logic [23:0]                na_s2;
	logic [NUM_COLOR-1:0][31:0] ca_s2;
	logic [NUM_COLOR-1:0][15:0] dd_s2;

	// stage 3: color numerators
	logic                       v_s3;
	logic [23:0]                na_s3;
	logic [NUM_COLOR-1:0][31:0] num_s3;

	logic [15:0] sa_c;
	logic [23:0] na_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 products
	always_ff @(posedge clk) begin
		a_s1     <= 16'(pix.alpha) * 16'(tint.alpha);
		cs_s1[0] <= 16'(pix.red) * 16'(tint.red);
		cs_s1[1] <= 16'(pix.green) * 16'(tint.green);
		cs_s1[2] <= 16'(pix.blue) * 16'(tint.blue);
		da_s1    <= pix.dest[31:24];
		d_s1[0]  <= pix.dest[23:16];
		d_s1[1]  <= pix.dest[15:8];
		d_s1[2]  <= pix.dest[7:0];
	end

	// na = 255*A + D*(S - A)
	assign sa_c = SQ_SCALE - a_s1;
	assign na_c = ({8'b0, a_s1} << 8) - {8'b0, a_s1} + (24'(da_s1) * 24'(sa_c));

	always_ff @(posedge clk) begin
		sa_s2 <= sa_c;
		na_s2 <= na_c;
		for (int c = 0; c < NUM_COLOR; c++) begin
			ca_s2[c] <= 32'(cs_s1[c]) * 32'(a_s1);
			dd_s2[c] <= 16'(d_s1[c]) * 16'(da_s1);
		end
	end

	// num = cs*A + d*D*(S - A)
	always_ff @(posedge clk) begin
		na_s3 <= na_s2;
		for (int c = 0; c < NUM_COLOR; c++) begin
			num_s3[c] <= ca_s2[c] + (32'(dd_s2[c]) * 32'(sa_s2));
		end
	end

	assign sum.valid = v_s3;
	assign sum.na    = na_s3;
	assign sum.num   = num_s3;

	// both alphas zero must leave nothing to divide
	`CHK_NEVER(a_zero_na_num, clk, arst_n, v_s3 && (na_s3 == '0) && (num_s3 != '0))

endmodule

`default_nettype wire

[rtl/taob_div.sv]
`default_nettype none

`include "assert_macros.svh"

module taob_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire taob_pkg::blend_sum_t sum,
	output logic                      result_valid,
	output logic [31:0]               result
);
	import taob_pkg::*;

	logic                       v_s4, v_s5, v_s6, v_s7;
	logic [23:0]                na_s4, na_s5, na_s6;
	logic [NUM_LANES-1:0][31:0] rem_s4, rem_s5, rem_s6;
	logic [NUM_LANES-1:0][7:0]  q_s4, q_s5, q_s6;
	logic [31:0]                pixel_s7;

	logic [NUM_LANES-1:0][31:0] rem_in;
	logic [NUM_LANES-1:0][31:0] rem_n4, rem_n5, rem_n6;
	logic [NUM_LANES-1:0][7:0]  q_n4, q_n5, q_n6, q_fin;
	logic [31:0]                pixel_n;

	// lane inputs: color numerators, alpha numerator over S
	always_comb begin
		for (int l = 0; l < NUM_COLOR; l++) begin
			rem_in[l] = sum.num[l];
		end
		rem_in[ALPHA_LANE] = {8'b0, sum.na};
	end

	// quotient bits 7 and 6
	always_comb begin
		div_pair_t p;
		for (int l = 0; l < NUM_LANES; l++) begin
			p = div_pair(rem_in[l], (l == ALPHA_LANE) ? 24'(SQ_SCALE) : sum.na, 7);
			rem_n4[l] = p.rem;
			q_n4[l]   = {6'b0, p.q};
		end
	end

	// quotient bits 5 and 4
	always_comb begin
		div_pair_t p;
		for (int l = 0; l < NUM_LANES; l++) begin
			p = div_pair(rem_s4[l], (l == ALPHA_LANE) ? 24'(SQ_SCALE) : na_s4, 5);
			rem_n5[l] = p.rem;
			q_n5[l]   = {q_s4[l][5:0], p.q};
		end
	end

	// quotient bits 3 and 2
	always_comb begin
		div_pair_t p;
		for (int l = 0; l < NUM_LANES; l++) begin
			p = div_pair(rem_s5[l], (l == ALPHA_LANE) ? 24'(SQ_SCALE) : na_s5, 3);
			rem_n6[l] = p.rem;
			q_n6[l]   = {q_s5[l][5:0], p.q};
		end
	end

	// quotient bits 1 and 0, zero alpha clears color, pack ARGB
	always_comb begin
		div_pair_t p;
		for (int l = 0; l < NUM_LANES; l++) begin
			p = div_pair(rem_s6[l], (l == ALPHA_LANE) ? 24'(SQ_SCALE) : na_s6, 1);
			q_fin[l] = {q_s6[l][5:0], p.q};
			if ((l != ALPHA_LANE) && (na_s6 == '0)) begin
				q_fin[l] = '0;
			end
		end
		pixel_n = {q_fin[ALPHA_LANE], q_fin[0], q_fin[1], q_fin[2]};
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s4 <= sum.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// divider payload
	always_ff @(posedge clk) begin
		na_s4    <= sum.na;
		rem_s4   <= rem_n4;
		q_s4     <= q_n4;
		na_s5    <= na_s4;
		rem_s5   <= rem_n5;
		q_s5     <= q_n5;
		na_s6    <= na_s5;
		rem_s6   <= rem_n6;
		q_s6     <= q_n6;
		pixel_s7 <= pixel_n;
	end

	assign result_valid = v_s7;
	assign result       = pixel_s7;

	// an 8-bit quotient needs num below 256 times the divisor
	`CHK_ASSERT(a_div_range, clk, arst_n,
		(sum.valid && (sum.na != '0)) |-> ((sum.num[0] < {sum.na, 8'b0}) &&
		(sum.num[1] < {sum.na, 8'b0}) && (sum.num[2] < {sum.na, 8'b0})))
	// every request entering the divider leaves it through the s4, s5, s6 and s7 registers
	`CHK_ASSERT(a_div_latency, clk, arst_n, sum.valid |-> ##4 v_s7)

endmodule

`default_nettype wire

[rtl/tinted_alpha_over_blend_core.sv]
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+---------------------------
// config    | psel penable pwrite paddr pwdata prdata pready | apb, write on access phase
// pixel in  | src_red src_green src_blue src_alpha dest_pixel | start while busy low
// pixel out | blended_pixel                                  | done, one cycle, no stall
//
// one pixel per clock; busy never rises
// three multiply stages, then four divider stages of two bits each
// the tint is sampled when a request enters, so writes apply to later requests
// arst_n clears the valid chain and sets all tints to 255
// results cannot be held off; a request in flight always comes out
`default_nettype none

`include "assert_macros.svh"

module tinted_alpha_over_blend_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// pixel request
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  src_red,
	input  wire logic [7:0]  src_green,
	input  wire logic [7:0]  src_blue,
	input  wire logic [7:0]  src_alpha,
	input  wire logic [31:0] dest_pixel,
	// result
	output logic             done,
	output logic [31:0]      blended_pixel
);
	import taob_pkg::*;

	tint_t      tint;
	pix_in_t    pix;
	blend_sum_t sum;
	logic       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pix    = '{red: src_red, green: src_green, blue: src_blue, alpha: src_alpha,
		dest: dest_pixel};

	// tint registers
	taob_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tint    (tint)
	);

	// multiply stages
	taob_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.pix      (pix),
		.tint     (tint),
		.sum      (sum)
	);

	// divider stages
	taob_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum          (sum),
		.result_valid (done),
		.result       (blended_pixel)
	);

	// each accepted request gives a result after the multiply and divider stages
	`CHK_ASSERT(a_core_latency, clk, arst_n, accept |-> ##7 done)

endmodule

`default_nettype wire
